### design/rfa_pkg.sv
// shared types and constants for the rational fraction alu
package rfa_pkg;
   localparam int OPERAND_BITS_DEFAULT = 16;
   localparam int OUT_BITS = 33;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } op_type;

   // controller to datapath commands
   typedef struct packed {
      logic load;
      logic mul_start;
      logic sum;
      logic gcd_init;
      logic gcd_start;
      logic gcd_swap;
      logic div_start;
      logic div_sel;
      logic quot_num;
      logic quot_den;
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic mul_done;
      logic gcd_zero;
      logic g_zero;
      logic div_done;
   } stat_type;
endpackage

### design/rfa_if.sv
// valid/ready channel interfaces for request and response beats
interface rfa_req_if #(parameter int OPERAND_BITS = rfa_pkg::OPERAND_BITS_DEFAULT);
   logic valid;
   logic ready;
   logic [1:0] action;
   logic signed [OPERAND_BITS-1:0] first_num;
   logic signed [OPERAND_BITS-1:0] first_den;
   logic signed [OPERAND_BITS-1:0] second_num;
   logic signed [OPERAND_BITS-1:0] second_den;
   modport source (output valid, action, first_num, first_den, second_num, second_den,
                   input ready);
   modport sink (input valid, action, first_num, first_den, second_num, second_den,
                 output ready);
endinterface

interface rfa_rsp_if;
   logic valid;
   logic ready;
   logic signed [rfa_pkg::OUT_BITS-1:0] result_num;
   logic signed [rfa_pkg::OUT_BITS-1:0] result_den;
   modport source (output valid, result_num, result_den, input ready);
   modport sink (input valid, result_num, result_den, output ready);
endinterface

### design/rfa_datapath.sv
// datapath: shift-add multiplier, remainder/quotient divider and result registers
module rfa_datapath #(
   parameter int OPERAND_BITS = rfa_pkg::OPERAND_BITS_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   input  rfa_pkg::cmd_type cmd,
   output rfa_pkg::stat_type stat,
   input  logic [1:0] action,
   input  logic [OPERAND_BITS-1:0] a_in,
   input  logic [OPERAND_BITS-1:0] b_in,
   input  logic [OPERAND_BITS-1:0] c_in,
   input  logic [OPERAND_BITS-1:0] d_in,
   output logic [rfa_pkg::OUT_BITS-1:0] num_out,
   output logic [rfa_pkg::OUT_BITS-1:0] den_out
);
   localparam int W = 64;
   localparam int CW = 7;

   logic [1:0] op_ff;
   logic [W-1:0] a_ff, b_ff, c_ff, d_ff;
   // three products formed in parallel by shift-add, one bit a cycle
   logic [W-1:0] p0_ff, p1_ff, p2_ff;      // num term 1, num term 2, den
   logic [W-1:0] m0_ff, m1_ff, m2_ff;      // shifting multiplicands
   logic [W-1:0] q0_ff, q1_ff, q2_ff;      // shifting multipliers
   logic [CW-1:0] mcnt_ff;
   logic mbusy_ff;
   logic [W-1:0] num_ff, den_ff;
   logic [W-1:0] x_ff, y_ff, g_ff;
   // restoring divider
   logic [W-1:0] dvd_ff, dvs_ff, rem_ff, quo_ff;
   logic [CW-1:0] dcnt_ff;
   logic dbusy_ff, ddone_ff;
   logic [rfa_pkg::OUT_BITS-1:0] rn_ff, rd_ff;

   function automatic logic [W-1:0] sext(input logic [OPERAND_BITS-1:0] v);
      return W'(signed'(v));
   endfunction

   function automatic logic [W-1:0] mag(input logic [W-1:0] v);
      return v[W-1] ? (W'(0) - v) : v;
   endfunction

   logic [W:0] rtrial;
   logic [W-1:0] rshift;
   assign rshift = {rem_ff[W-2:0], dvd_ff[W-1]};
   assign rtrial = {1'b0, rshift} - {1'b0, dvs_ff};

   // multiplicand / multiplier routing per operation
   logic [W-1:0] ma, mb, mc, qa, qb, qc;
   always_comb begin
      ma = a_ff; qa = d_ff;
      mb = c_ff; qb = b_ff;
      mc = b_ff; qc = d_ff;
      if (op_ff == rfa_pkg::OP_MUL) begin
         qa = c_ff;
      end
      if (op_ff == rfa_pkg::OP_DIV) begin
         qc = c_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mbusy_ff <= 1'b0;
         dbusy_ff <= 1'b0;
         ddone_ff <= 1'b0;
      end else begin
         ddone_ff <= 1'b0;
         if (cmd.load) begin
            op_ff <= action;
            a_ff <= sext(a_in); b_ff <= sext(b_in);
            c_ff <= sext(c_in); d_ff <= sext(d_in);
         end
         if (cmd.mul_start) begin
            m0_ff <= ma; q0_ff <= qa; m1_ff <= mb; q1_ff <= qb;
            m2_ff <= mc; q2_ff <= qc;
            p0_ff <= '0; p1_ff <= '0; p2_ff <= '0;
            mcnt_ff <= '0;
            mbusy_ff <= 1'b1;
         end else if (mbusy_ff) begin
            if (q0_ff[0]) p0_ff <= p0_ff + m0_ff;
            if (q1_ff[0]) p1_ff <= p1_ff + m1_ff;
            if (q2_ff[0]) p2_ff <= p2_ff + m2_ff;
            m0_ff <= m0_ff << 1; m1_ff <= m1_ff << 1; m2_ff <= m2_ff << 1;
            q0_ff <= q0_ff >> 1; q1_ff <= q1_ff >> 1; q2_ff <= q2_ff >> 1;
            mcnt_ff <= mcnt_ff + 1'b1;
            if (mcnt_ff == CW'(W - 1)) mbusy_ff <= 1'b0;
         end
         // combine products into raw fraction
         if (cmd.sum) begin
            den_ff <= p2_ff;
            if (op_ff == rfa_pkg::OP_ADD) num_ff <= p0_ff + p1_ff;
            else if (op_ff == rfa_pkg::OP_SUB) num_ff <= p0_ff - p1_ff;
            else num_ff <= p0_ff;
         end
         if (cmd.gcd_init) begin
            x_ff <= mag(num_ff);
            y_ff <= mag(den_ff);
         end
         // euclid step: x <= y, y <= x mod y
         if (cmd.gcd_swap) begin
            x_ff <= y_ff;
            y_ff <= rem_ff;
         end
         if (cmd.div_start) begin
            if (cmd.gcd_start) begin
               dvd_ff <= x_ff; dvs_ff <= y_ff;
            end else begin
               dvd_ff <= cmd.div_sel ? mag(den_ff) : mag(num_ff);
               dvs_ff <= g_ff;
            end
            rem_ff <= '0; quo_ff <= '0;
            dcnt_ff <= '0;
            dbusy_ff <= 1'b1;
         end else if (dbusy_ff) begin
            if (!rtrial[W]) begin
               rem_ff <= rtrial[W-1:0];
               quo_ff <= {quo_ff[W-2:0], 1'b1};
            end else begin
               rem_ff <= rshift;
               quo_ff <= {quo_ff[W-2:0], 1'b0};
            end
            dvd_ff <= dvd_ff << 1;
            dcnt_ff <= dcnt_ff + 1'b1;
            if (dcnt_ff == CW'(W - 1)) begin
               dbusy_ff <= 1'b0;
               ddone_ff <= 1'b1;
            end
         end
         // capture gcd when y reaches zero
         if (!cmd.gcd_swap && !cmd.gcd_init && y_ff == '0) g_ff <= x_ff;
         // signed quotients, or pass-through when gcd is zero
         if (cmd.quot_num && cmd.quot_den) begin
            rn_ff <= rfa_pkg::OUT_BITS'(num_ff);
            rd_ff <= rfa_pkg::OUT_BITS'(den_ff);
         end else if (cmd.quot_num) begin
            rn_ff <= rfa_pkg::OUT_BITS'(num_ff[W-1] ? (W'(0) - quo_ff) : quo_ff);
         end else if (cmd.quot_den) begin
            rd_ff <= rfa_pkg::OUT_BITS'(den_ff[W-1] ? (W'(0) - quo_ff) : quo_ff);
         end
      end
   end

   assign stat.mul_done = !mbusy_ff && !cmd.mul_start;
   assign stat.gcd_zero = (y_ff == '0);
   assign stat.g_zero = (x_ff == '0);
   assign stat.div_done = ddone_ff;
   assign num_out = rn_ff;
   assign den_out = rd_ff;
endmodule

### design/rfa_ctrl.sv
// controller: sequences multiply, euclid loop, exact divides and response beat
module rfa_ctrl (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   output logic rsp_valid,
   input  logic rsp_ready,
   output rfa_pkg::cmd_type cmd,
   input  rfa_pkg::stat_type stat
);
   typedef enum logic [9:0] {
      S_IDLE  = 10'b0000000001,
      S_MUL   = 10'b0000000010,
      S_SUM   = 10'b0000000100,
      S_GINIT = 10'b0000001000,
      S_GTEST = 10'b0000010000,
      S_GDIV  = 10'b0000100000,
      S_NDIV  = 10'b0001000000,
      S_DDIV  = 10'b0010000000,
      S_SETG  = 10'b0100000000,
      S_OUT   = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;
   logic started_ff, started_in;

   always_comb begin
      state_in = state_ff;
      started_in = 1'b0;
      cmd = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_MUL;
               started_in = 1'b1;
            end
         end
         S_MUL: begin
            if (started_ff) cmd.mul_start = 1'b1;
            else if (stat.mul_done) state_in = S_SUM;
         end
         S_SUM: begin
            cmd.sum = 1'b1;
            state_in = S_GINIT;
         end
         S_GINIT: begin
            cmd.gcd_init = 1'b1;
            state_in = S_GTEST;
         end
         S_GTEST: begin
            // y zero: x is the gcd, latched into g this cycle
            if (stat.gcd_zero) begin
               state_in = S_SETG;
            end else begin
               cmd.div_start = 1'b1;
               cmd.gcd_start = 1'b1;
               state_in = S_GDIV;
            end
         end
         S_GDIV: begin
            if (stat.div_done) begin
               cmd.gcd_swap = 1'b1;
               state_in = S_GTEST;
            end
         end
         S_SETG: begin
            if (stat.g_zero) begin
               cmd.quot_num = 1'b1;
               cmd.quot_den = 1'b1;
               state_in = S_OUT;
            end else begin
               cmd.div_start = 1'b1;
               state_in = S_NDIV;
            end
         end
         S_NDIV: begin
            if (stat.div_done) begin
               cmd.quot_num = 1'b1;
               cmd.div_start = 1'b1;
               cmd.div_sel = 1'b1;
               state_in = S_DDIV;
            end
         end
         S_DDIV: begin
            if (stat.div_done) begin
               cmd.quot_den = 1'b1;
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         started_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         started_ff <= started_in;
      end
   end

   a_onehot: assert property (@(posedge clock) disable iff (reset) $onehot(state_ff))
      else $error("state not one-hot");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !rsp_valid) else $error("ready while result held");
   a_load: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == S_MUL))
      else $error("accepted beat did not start multiply");
endmodule

### design/rational_fraction_alu_core.sv
// Each item runs the multiply, the euclid steps (one divide each) and the two exact
// divides in turn, on the shift-add multiplier and the restoring divider; 0/0 needs no divide.
// One item at a time; the next request beat is taken the cycle after the response beat.
// Synchronous active-high reset returns the controller to idle; no data is cleared.
module rational_fraction_alu_core #(
   parameter int OPERAND_BITS = rfa_pkg::OPERAND_BITS_DEFAULT
) (
   input logic clock,
   input logic reset,
   rfa_req_if.sink req,
   rfa_rsp_if.source rsp
);
   rfa_pkg::cmd_type cmd;
   rfa_pkg::stat_type stat;

   rfa_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req.valid), .req_ready(req.ready),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
      .cmd(cmd), .stat(stat)
   );

   rfa_datapath #(.OPERAND_BITS(OPERAND_BITS)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .stat(stat),
      .action(req.action),
      .a_in(req.first_num), .b_in(req.first_den),
      .c_in(req.second_num), .d_in(req.second_den),
      .num_out(rsp.result_num), .den_out(rsp.result_den)
   );
endmodule

### verif/tb_top.sv
// self-checking testbench for the rational fraction alu core
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int OPB = rfa_pkg::OPERAND_BITS_DEFAULT;
   localparam int RANDOM_ITEMS = 1250;
   localparam int DRAIN_CYCLES = 400;

   typedef struct {
      rfa_pkg::op_type action;
      logic signed [OPB-1:0] a;
      logic signed [OPB-1:0] b;
      logic signed [OPB-1:0] c;
      logic signed [OPB-1:0] d;
      bit hold;
   } fraction_pair;

   typedef struct {
      logic signed [rfa_pkg::OUT_BITS-1:0] num;
      logic signed [rfa_pkg::OUT_BITS-1:0] den;
   } reduced_fraction;

   logic clock = 1'b0;
   logic reset = 1'b1;

   rfa_req_if #(.OPERAND_BITS(OPB)) req ();
   rfa_rsp_if rsp ();

   rational_fraction_alu_core #(.OPERAND_BITS(OPB)) dut (
      .clock(clock),
      .reset(reset),
      .req(req.sink),
      .rsp(rsp.source)
   );

   fraction_pair pending_pairs[$];
   reduced_fraction expected_fractions[$];
   int mismatches = 0;
   int req_gap = 0;
   int rsp_stall = 0;
   int burst_left = 0;
   bit burst_mode = 0;

   always #5 clock = ~clock;

   initial begin
      req.valid = 1'b0;
      req.action = rfa_pkg::OP_ADD;
      req.first_num = '0;
      req.first_den = '0;
      req.second_num = '0;
      req.second_den = '0;
      rsp.ready = 1'b0;
   end

   // magnitude of a 64-bit two's complement value
   function automatic logic [63:0] abs64(logic [63:0] v);
      return v[63] ? (64'd0 - v) : v;
   endfunction

   // signed quotient by a positive divisor
   function automatic logic [63:0] div_exact(logic [63:0] v, logic [63:0] g);
      logic [63:0] q;
      q = abs64(v) / g;
      return v[63] ? (64'd0 - q) : q;
   endfunction

   // cross-multiply, then reduce by the euclidean gcd of the magnitudes
   function automatic reduced_fraction reduce_fraction(rfa_pkg::op_type op,
         logic signed [OPB-1:0] a, logic signed [OPB-1:0] b,
         logic signed [OPB-1:0] c, logic signed [OPB-1:0] d);
      logic [63:0] wa, wb, wc, wd, num, den, x, y, r;
      reduced_fraction res;
      wa = 64'($signed(a));
      wb = 64'($signed(b));
      wc = 64'($signed(c));
      wd = 64'($signed(d));
      case (op)
         rfa_pkg::OP_ADD: begin num = wa * wd + wc * wb; den = wb * wd; end
         rfa_pkg::OP_SUB: begin num = wa * wd - wc * wb; den = wb * wd; end
         rfa_pkg::OP_MUL: begin num = wa * wc; den = wb * wd; end
         default: begin num = wa * wd; den = wb * wc; end
      endcase
      x = abs64(num);
      y = abs64(den);
      while (y != 0) begin
         r = x % y;
         x = y;
         y = r;
      end
      if (x != 0) begin
         num = div_exact(num, x);
         den = div_exact(den, x);
      end
      res.num = num[rfa_pkg::OUT_BITS-1:0];
      res.den = den[rfa_pkg::OUT_BITS-1:0];
      return res;
   endfunction

   // mostly short gaps, a few long ones, none inside a burst
   function automatic int pick_gap(bit no_idle);
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 55) return 0;
      if (r < 92) return $urandom_range(1, 4);
      return $urandom_range(10, 80);
   endfunction

   // operand value biased toward extremes and small magnitudes
   function automatic logic signed [OPB-1:0] pick_operand();
      int r;
      r = $urandom_range(0, 9);
      case (r)
         0: return 16'sh8000;
         1: return 16'sh7fff;
         2: return '0;
         3, 4: return OPB'($signed($urandom_range(0, 40)) - 20);
         default: return OPB'($urandom);
      endcase
   endfunction

   function automatic fraction_pair make_pair(rfa_pkg::op_type op, int a, int b, int c, int d,
         bit hold);
      fraction_pair p;
      p.action = op;
      p.a = OPB'(a);
      p.b = OPB'(b);
      p.c = OPB'(c);
      p.d = OPB'(d);
      p.hold = hold;
      return p;
   endfunction

   // request driver: predict on each accepted beat, then load the next one
   always @(posedge clock) begin
      if (reset) begin
         req.valid <= 1'b0;
         req_gap = 0;
      end else begin
         if (req.valid && req.ready) begin
            expected_fractions.push_back(reduce_fraction(rfa_pkg::op_type'(req.action),
               req.first_num, req.first_den, req.second_num, req.second_den));
            if (burst_left > 0) burst_left--;
            else begin
               burst_mode = ($urandom_range(0, 19) == 0);
               burst_left = burst_mode ? $urandom_range(10, 30) : 0;
            end
            req_gap = pick_gap(burst_mode && burst_left > 0);
         end
         if (!req.valid || req.ready) begin
            if (req_gap > 0) begin
               req_gap--;
               req.valid <= 1'b0;
            end else if (pending_pairs.size() > 0 &&
                         !(pending_pairs[0].hold && expected_fractions.size() > 0)) begin
               fraction_pair p;
               p = pending_pairs.pop_front();
               req.valid <= 1'b1;
               req.action <= p.action;
               req.first_num <= p.a;
               req.first_den <= p.b;
               req.second_num <= p.c;
               req.second_den <= p.d;
            end else begin
               req.valid <= 1'b0;
            end
         end
      end
   end

   // response monitor with random back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
         rsp_stall = 0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (expected_fractions.size() == 0) begin
               $error("response beat with nothing expected: num %0d den %0d",
                  rsp.result_num, rsp.result_den);
               mismatches++;
            end else begin
               reduced_fraction e;
               e = expected_fractions.pop_front();
               if (rsp.result_num !== e.num) begin
                  $error("result_num expected %0d actual %0d", e.num, rsp.result_num);
                  mismatches++;
               end
               if (rsp.result_den !== e.den) begin
                  $error("result_den expected %0d actual %0d", e.den, rsp.result_den);
                  mismatches++;
               end
            end
         end
         // stall runs of random length, mostly short
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp.ready <= 1'b0;
         end else begin
            rsp_stall = pick_gap(burst_mode && burst_left > 0);
            rsp.ready <= (rsp_stall == 0);
         end
      end
   end

   // stimulus and end of run
   initial begin
      rfa_pkg::op_type op;
      // directed: extremes, every operation, zero denominators and numerators
      for (int k = 0; k < 4; k++) begin
         op = rfa_pkg::op_type'(k);
         pending_pairs.push_back(make_pair(op, -32768, -32768, -32768, -32768, 0));
         pending_pairs.push_back(make_pair(op, 32767, -32768, 32767, 32767, 0));
         pending_pairs.push_back(make_pair(op, 3, 0, 5, 7, 0));
         pending_pairs.push_back(make_pair(op, 0, -6, 0, 4, 0));
         pending_pairs.push_back(make_pair(op, 0, 0, 0, 0, 0));
      end
      pending_pairs.push_back(make_pair(rfa_pkg::OP_DIV, 5, 3, 0, 7, 0));
      pending_pairs.push_back(make_pair(rfa_pkg::OP_SUB, 1, 2, 1, 2, 1));
      pending_pairs.push_back(make_pair(rfa_pkg::OP_ADD, -1, 3, 1, -6, 0));
      pending_pairs.push_back(make_pair(rfa_pkg::OP_MUL, -32768, 32767, 32767, -32768, 0));
      // random items, with an occasional wait for the pipe to drain
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         pending_pairs.push_back(make_pair(rfa_pkg::op_type'($urandom_range(0, 3)),
            pick_operand(), pick_operand(), pick_operand(), pick_operand(),
            (n % 300) == 150));
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (pending_pairs.size() > 0 || req.valid) @(posedge clock);
      while (expected_fractions.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // watchdog
   initial begin
      #200ms;
      $display("end of test: mismatches");
      $finish;
   end
endmodule
